/* hw/rtl/rms_pkg.sv */
// Shared types and constants of the RMS meter.
package rms_pkg;

  // Accumulator width and its saturation value.
  localparam int unsigned SUM_W = 48;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Root of a SUM_W-bit value has half as many bits.
  localparam int unsigned ROOT_W = SUM_W / 2;

  // Result field widths.
  localparam int unsigned RMS_W = 16;
  localparam int unsigned LEN_W = 17;

  // Iteration counter of the back end covers SUM_W divide steps.
  localparam int unsigned STEP_W = $clog2(SUM_W);

  // Run queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QLVL_W = $clog2(QUEUE_DEPTH + 1);

  // Front status: queue push this cycle and run ends still in flight.
  typedef struct packed {
    logic       push;
    logic [1:0] pending;
  } front_stat_t;

  // Queue status.
  typedef struct packed {
    logic              empty;
    logic [QLVL_W-1:0] level;
  } queue_stat_t;

  // Back-end sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_ROOT = 4'b0100,
    ST_DONE = 4'b1000
  } back_state_t;

endpackage

/* hw/rtl/rms_meter_top.sv */
// Top level of the RMS meter: front accumulator, run queue, divide/root back end.
//
//  Channel | Handshake           | Word
//  --------+---------------------+--------------------------------------
//  in      | in_valid, in_ready  | sample, is_last
//  out     | out_valid,out_ready | rms_value, run_length, overflow
//
// Flow: one sample word per cycle while in_ready is high. A sample passes
// through the front pipe stages (magnitude, square, sum); a run's end then
// waits in a four-deep queue and goes through the back end, one run at a
// time, by the bit-serial divider and the two-bit-per-cycle root.
// Reset: rst clears the accumulators, the queue and the back-end sequencer.
// Stalls: in_ready drops only when the queue plus run ends still in the
// front pipe would fill it; a waiting result does not block the back end
// from starting on the next run until that run is finished too.
module rms_meter_top #(
  parameter int unsigned MAX_SAMPLES = 65536,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [15:0]        sample,
  input  logic                      is_last,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [rms_pkg::RMS_W-1:0] rms_value,
  output logic [rms_pkg::LEN_W-1:0] run_length,
  output logic                      overflow
);

  // Count holds MAX_SAMPLES itself.
  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);

  rms_pkg::front_stat_t      fstat;
  rms_pkg::queue_stat_t      qstat;
  logic                      accept;
  logic                      pop;
  logic [rms_pkg::SUM_W-1:0] push_sum, rd_sum;
  logic [CNT_W-1:0]          push_cnt, rd_cnt;
  logic                      push_drop, rd_drop;
  logic [rms_pkg::QLVL_W:0]  committed;

  // Reserve a queue slot for every run end already inside the front pipe.
  assign committed = (rms_pkg::QLVL_W + 1)'(qstat.level) + (rms_pkg::QLVL_W + 1)'(fstat.pending);
  assign in_ready  = (committed < (rms_pkg::QLVL_W + 1)'(rms_pkg::QUEUE_DEPTH));
  assign accept    = in_valid && in_ready;

  rms_front #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS),
    .CNT_W       (CNT_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .sample    (sample),
    .is_last   (is_last),
    .stat      (fstat),
    .push_sum  (push_sum),
    .push_cnt  (push_cnt),
    .push_drop (push_drop)
  );

  rms_queue #(
    .CNT_W (CNT_W)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (fstat.push),
    .wr_sum  (push_sum),
    .wr_cnt  (push_cnt),
    .wr_drop (push_drop),
    .pop     (pop),
    .rd_sum  (rd_sum),
    .rd_cnt  (rd_cnt),
    .rd_drop (rd_drop),
    .stat    (qstat)
  );

  rms_back #(
    .CNT_W (CNT_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .qstat      (qstat),
    .rd_sum     (rd_sum),
    .rd_cnt     (rd_cnt),
    .rd_drop    (rd_drop),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .rms_value  (rms_value),
    .run_length (run_length),
    .overflow   (overflow)
  );

  // A run end never arrives at a full queue.
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    fstat.push |-> (qstat.level < rms_pkg::QLVL_W'(rms_pkg::QUEUE_DEPTH)))
    else $error("run pushed into full queue");

  // Queue level stays within its depth.
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    qstat.level <= rms_pkg::QLVL_W'(rms_pkg::QUEUE_DEPTH))
    else $error("queue level out of range");

  // A run that dropped samples reports exactly the cap as its length.
  a_overflow_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflow) |-> (run_length == rms_pkg::LEN_W'(MAX_SAMPLES)))
    else $error("overflow run with wrong length");

endmodule

/* hw/rtl/rms_front.sv */
// Front end: take samples, square them and accumulate per run.
module rms_front #(
  parameter int unsigned MAX_SAMPLES = 65536,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned CNT_W       = 17
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  logic signed [15:0]       sample,
  input  logic                     is_last,
  output rms_pkg::front_stat_t     stat,
  output logic [rms_pkg::SUM_W-1:0] push_sum,
  output logic [CNT_W-1:0]         push_cnt,
  output logic                     push_drop
);

  localparam int unsigned EXT_W = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
  localparam int unsigned SQ_W  = 2 * SAMPLE_BITS;

  logic [EXT_W-1:0]       raw_ext;
  logic [SAMPLE_BITS-1:0] raw;
  logic                   take;
  logic [CNT_W-1:0]       total_upd;
  logic                   drop_upd;

  logic [CNT_W-1:0]       total;
  logic                   dropped;

  // Stage A: magnitude and run bookkeeping.
  logic                   a_valid, a_take, a_last, a_drop;
  logic [SAMPLE_BITS-1:0] a_mag;
  logic [CNT_W-1:0]       a_cnt;

  // Stage B: square.
  logic                   b_valid, b_take, b_last, b_drop;
  logic [SQ_W-1:0]        b_sq;
  logic [CNT_W-1:0]       b_cnt;

  // Stage C: sum.
  logic [rms_pkg::SUM_W-1:0] sum;
  logic [rms_pkg::SUM_W:0]   sum_add;
  logic [rms_pkg::SUM_W-1:0] sum_next;

  assign raw_ext   = EXT_W'($unsigned(sample));
  assign raw       = raw_ext[SAMPLE_BITS-1:0];
  assign take      = (total < CNT_W'(MAX_SAMPLES));
  assign total_upd = take ? total + CNT_W'(1) : total;
  assign drop_upd  = dropped | ~take;

  always_ff @(posedge clk) begin
    if (rst) begin
      total   <= '0;
      dropped <= 1'b0;
      a_valid <= 1'b0;
    end else begin
      a_valid <= accept;
      if (accept) begin
        // Clear the run on its last word; the snapshot travels down the pipe.
        total   <= is_last ? '0 : total_upd;
        dropped <= is_last ? 1'b0 : drop_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_take <= take;
      a_last <= is_last;
      a_mag  <= raw[SAMPLE_BITS-1] ? (~raw + SAMPLE_BITS'(1)) : raw;
      a_cnt  <= total_upd;
      a_drop <= drop_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    b_take <= a_take;
    b_last <= a_last;
    b_sq   <= SQ_W'(a_mag) * SQ_W'(a_mag);
    b_cnt  <= a_cnt;
    b_drop <= a_drop;
  end

  // Saturate the running sum at its top value.
  assign sum_add  = {1'b0, sum} + (rms_pkg::SUM_W + 1)'(b_sq);
  assign sum_next = (b_valid && b_take)
                  ? (sum_add[rms_pkg::SUM_W] ? rms_pkg::SUM_MAX
                                             : sum_add[rms_pkg::SUM_W-1:0])
                  : sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (b_valid && b_last) begin
      sum <= '0;
    end else begin
      sum <= sum_next;
    end
  end

  assign push_sum     = sum_next;
  assign push_cnt     = b_cnt;
  assign push_drop    = b_drop;
  assign stat.push    = b_valid & b_last;
  assign stat.pending = {1'b0, a_valid & a_last} + {1'b0, b_valid & b_last};

endmodule

/* hw/rtl/rms_queue.sv */
// Short queue of finished runs between front and back.
module rms_queue #(
  parameter int unsigned CNT_W = 17
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic [rms_pkg::SUM_W-1:0] wr_sum,
  input  logic [CNT_W-1:0]          wr_cnt,
  input  logic                      wr_drop,
  input  logic                      pop,
  output logic [rms_pkg::SUM_W-1:0] rd_sum,
  output logic [CNT_W-1:0]          rd_cnt,
  output logic                      rd_drop,
  output rms_pkg::queue_stat_t      stat
);

  logic [rms_pkg::SUM_W-1:0]  sum_q  [rms_pkg::QUEUE_DEPTH];
  logic [CNT_W-1:0]           cnt_q  [rms_pkg::QUEUE_DEPTH];
  logic                       drop_q [rms_pkg::QUEUE_DEPTH];
  logic [rms_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [rms_pkg::QLVL_W-1:0] level;

  always_ff @(posedge clk) begin
    if (push) begin
      sum_q[wr_ptr]  <= wr_sum;
      cnt_q[wr_ptr]  <= wr_cnt;
      drop_q[wr_ptr] <= wr_drop;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + rms_pkg::QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + rms_pkg::QPTR_W'(1);
      case ({push, pop})
        2'b10:   level <= level + rms_pkg::QLVL_W'(1);
        2'b01:   level <= level - rms_pkg::QLVL_W'(1);
        default: level <= level;
      endcase
    end
  end

  assign rd_sum     = sum_q[rd_ptr];
  assign rd_cnt     = cnt_q[rd_ptr];
  assign rd_drop    = drop_q[rd_ptr];
  assign stat.empty = (level == '0);
  assign stat.level = level;

endmodule

/* hw/rtl/rms_back.sv */
// Back end: serial divide by the count, serial square root, result register.
module rms_back #(
  parameter int unsigned CNT_W = 17
) (
  input  logic                        clk,
  input  logic                        rst,
  input  rms_pkg::queue_stat_t        qstat,
  input  logic [rms_pkg::SUM_W-1:0]   rd_sum,
  input  logic [CNT_W-1:0]            rd_cnt,
  input  logic                        rd_drop,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rms_pkg::RMS_W-1:0]   rms_value,
  output logic [rms_pkg::LEN_W-1:0]   run_length,
  output logic                        overflow
);

  localparam int unsigned SW = rms_pkg::SUM_W;
  localparam int unsigned RW = rms_pkg::ROOT_W;

  rms_pkg::back_state_t state;

  logic [rms_pkg::STEP_W-1:0] step;
  logic [SW-1:0]              dvd;
  logic [CNT_W-1:0]           rem;
  logic [CNT_W-1:0]           divisor;
  logic                       drop;
  logic [RW-1:0]              root;
  logic [RW:0]                rrem;

  logic [CNT_W:0]             rem_sh, rem_diff;
  logic                       div_ge;
  logic [RW+2:0]              trial, trial_sub, trial_diff;
  logic                       root_ge;
  logic                       can_load;

  assign rem_sh   = {rem, dvd[SW-1]};
  assign rem_diff = rem_sh - {1'b0, divisor};
  assign div_ge   = (rem_sh >= {1'b0, divisor});

  assign trial      = {rrem, dvd[SW-1:SW-2]};
  assign trial_sub  = {1'b0, root, 2'b01};
  assign trial_diff = trial - trial_sub;
  assign root_ge    = (trial >= trial_sub);

  assign pop      = (state == rms_pkg::ST_IDLE) && !qstat.empty;
  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rms_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // Load a new result, or drop the one just taken.
      if ((state == rms_pkg::ST_DONE) && can_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        rms_pkg::ST_IDLE: begin
          if (pop) state <= rms_pkg::ST_DIV;
        end
        rms_pkg::ST_DIV: begin
          if (step == rms_pkg::STEP_W'(SW - 1)) state <= rms_pkg::ST_ROOT;
        end
        rms_pkg::ST_ROOT: begin
          if (step == rms_pkg::STEP_W'(RW - 1)) state <= rms_pkg::ST_DONE;
        end
        rms_pkg::ST_DONE: begin
          if (can_load) begin
            state <= rms_pkg::ST_IDLE;
          end
        end
        default: state <= rms_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      rms_pkg::ST_IDLE: begin
        dvd     <= rd_sum;
        divisor <= rd_cnt;
        drop    <= rd_drop;
        rem     <= '0;
        step    <= '0;
      end
      rms_pkg::ST_DIV: begin
        // Restoring divide, one quotient bit per cycle, MSB first.
        rem  <= div_ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        dvd  <= {dvd[SW-2:0], div_ge};
        step <= (step == rms_pkg::STEP_W'(SW - 1)) ? '0 : step + rms_pkg::STEP_W'(1);
        root <= '0;
        rrem <= '0;
      end
      rms_pkg::ST_ROOT: begin
        // Digit-by-digit root, two radicand bits per cycle.
        rrem <= root_ge ? trial_diff[RW:0] : trial[RW:0];
        root <= {root[RW-2:0], root_ge};
        dvd  <= {dvd[SW-3:0], 2'b00};
        step <= step + rms_pkg::STEP_W'(1);
      end
      rms_pkg::ST_DONE: begin
        if (can_load) begin
          rms_value  <= (divisor == '0) ? '0 : rms_pkg::RMS_W'(root);
          run_length <= rms_pkg::LEN_W'(divisor);
          overflow   <= drop;
        end
      end
      default: step <= '0;
    endcase
  end

endmodule
